### hw/rtl/tcd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcd_pkg
// Types, palette tables and helpers for the terminal color downgrade block.
// ----------------------------------------------------------------------------
package tcd_pkg;

    typedef struct packed {
        logic [23:0] fg_color;
        logic [23:0] bg_color;
        logic [4:0]  attr_bits;
    } t_in_item;

    typedef struct packed {
        logic [23:0] fg_out;
        logic [23:0] bg_out;
        logic [4:0]  attr_out;
    } t_out_item;

    // color modes
    localparam logic [1:0] MODE_RGB     = 2'd0;
    localparam logic [1:0] MODE_XTERM   = 2'd1;
    localparam logic [1:0] MODE_ANSI    = 2'd2;
    localparam logic [1:0] MODE_UNKNOWN = 2'd3;

    // register indexes
    localparam logic REG_PAL_MODE   = 1'b0;
    localparam logic REG_SUPP_ATTRS = 1'b1;

    localparam int CFG_WIDTH = 5;

    localparam logic [1:0] PAL_MODE_RESET   = MODE_RGB;
    localparam logic [4:0] SUPP_ATTRS_RESET = 5'h1F;

    // xterm cube and gray ramp
    localparam logic [7:0] CUBE_BASE  = 8'd16;
    localparam logic [7:0] GRAY_BASE  = 8'd232;
    localparam int         GRAY_COUNT = 24;
    localparam int         GRAY_FIRST = 8;
    localparam int         GRAY_STEP  = 10;

    // channel sum thresholds between neighbor gray levels
    localparam int GRAY_SPLIT0     = 3 * GRAY_FIRST + (3 * GRAY_STEP) / 2;
    localparam int GRAY_SPLIT_STEP = 3 * GRAY_STEP;

    localparam logic [7:0] CUBE_LEVELS [6] = '{8'd0, 8'd95, 8'd135, 8'd175, 8'd215, 8'd255};
    // lowest channel value that moves to the next cube level
    localparam logic [7:0] CUBE_SPLIT [5] = '{8'd48, 8'd116, 8'd156, 8'd196, 8'd236};

    localparam logic [23:0] ANSI_PAL [16] = '{
        24'h000000, 24'hCD0000, 24'h00CD00, 24'hCDCD00,
        24'h0000EE, 24'hCD00CD, 24'h00CDCD, 24'hE5E5E5,
        24'h7F7F7F, 24'hFF0000, 24'h00FF00, 24'hFFFF00,
        24'h5C5CFF, 24'hFF00FF, 24'h00FFFF, 24'hFFFFFF
    };

    function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return {8'b0, d} * {8'b0, d};
    endfunction

    function automatic logic [17:0] dist3(input logic [23:0] c, input logic [23:0] p);
        return {2'b0, sq_diff(c[23:16], p[23:16])} + {2'b0, sq_diff(c[15:8], p[15:8])}
             + {2'b0, sq_diff(c[7:0], p[7:0])};
    endfunction

endpackage
`default_nettype wire

### hw/rtl/tcd_xterm256.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcd_xterm256
// Nearest xterm-256 index: cube candidate against the nearest gray level.
// ----------------------------------------------------------------------------
module tcd_xterm256
    import tcd_pkg::*;
(
    input  wire logic [23:0] i_rgb,
    output logic      [7:0]  o_index
);

    logic [7:0]  chan [3];
    logic [2:0]  lvl [3];
    logic [9:0]  sum;
    logic [4:0]  gray_sel;
    logic [7:0]  gray_lvl;
    logic [17:0] cube_d;
    logic [17:0] gray_d;
    logic [7:0]  cube_code;

    always_comb begin
        chan[0] = i_rgb[23:16];
        chan[1] = i_rgb[15:8];
        chan[2] = i_rgb[7:0];
        for (int c = 0; c < 3; c++) begin
            lvl[c] = 3'd0;
            for (int k = 0; k < 5; k++) begin
                if (chan[c] >= CUBE_SPLIT[k]) begin
                    lvl[c] = lvl[c] + 3'd1;
                end
            end
        end
    end

    always_comb begin
        sum = {2'b0, chan[0]} + {2'b0, chan[1]} + {2'b0, chan[2]};
        gray_sel = 5'd0;
        for (int k = 0; k < GRAY_COUNT - 1; k++) begin
            if (sum > 10'(GRAY_SPLIT0 + GRAY_SPLIT_STEP * k)) begin
                gray_sel = gray_sel + 5'd1;
            end
        end
        gray_lvl = 8'(GRAY_FIRST) + 8'(gray_sel) * 8'(GRAY_STEP);
    end

    always_comb begin
        cube_d = dist3(i_rgb, {CUBE_LEVELS[lvl[0]], CUBE_LEVELS[lvl[1]], CUBE_LEVELS[lvl[2]]});
        gray_d = dist3(i_rgb, {gray_lvl, gray_lvl, gray_lvl});
        cube_code = CUBE_BASE + 8'(lvl[0]) * 8'd36 + 8'(lvl[1]) * 8'd6 + 8'(lvl[2]);
        // equal distance keeps the cube
        o_index = (gray_d < cube_d) ? (GRAY_BASE + 8'(gray_sel)) : cube_code;
    end

endmodule
`default_nettype wire

### hw/rtl/tcd_ansi16.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcd_ansi16
// Nearest of the 16 ANSI palette entries through a min tree, lower index on tie.
// ----------------------------------------------------------------------------
module tcd_ansi16
    import tcd_pkg::*;
(
    input  wire logic [23:0] i_rgb,
    output logic      [3:0]  o_index
);

    typedef struct packed {
        logic [17:0] d;
        logic [3:0]  idx;
    } t_cand;

    function automatic t_cand pick(input t_cand a, input t_cand b);
        return (b.d < a.d) ? b : a;
    endfunction

    t_cand c0 [16];
    t_cand c1 [8];
    t_cand c2 [4];
    t_cand c3 [2];
    t_cand best;

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            c0[i].d   = dist3(i_rgb, ANSI_PAL[i]);
            c0[i].idx = 4'(i);
        end
        for (int i = 0; i < 8; i++) begin
            c1[i] = pick(c0[2 * i], c0[2 * i + 1]);
        end
        for (int i = 0; i < 4; i++) begin
            c2[i] = pick(c1[2 * i], c1[2 * i + 1]);
        end
        for (int i = 0; i < 2; i++) begin
            c3[i] = pick(c2[2 * i], c2[2 * i + 1]);
        end
        best    = pick(c3[0], c3[1]);
        o_index = best.idx;
    end

endmodule
`default_nettype wire

### hw/rtl/tcd_conv.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcd_conv
// Converts one color according to the color mode.
// ----------------------------------------------------------------------------
module tcd_conv
    import tcd_pkg::*;
(
    input  wire logic [23:0] i_rgb,
    input  wire logic [1:0]  i_mode,
    output logic      [23:0] o_color
);

    logic [7:0] xterm_idx;
    logic [3:0] ansi_idx;

    tcd_xterm256 u_xterm (
        .i_rgb   (i_rgb),
        .o_index (xterm_idx)
    );

    tcd_ansi16 u_ansi (
        .i_rgb   (i_rgb),
        .o_index (ansi_idx)
    );

    always_comb begin
        case (i_mode)
            MODE_RGB:     o_color = i_rgb;
            MODE_XTERM:   o_color = {16'b0, xterm_idx};
            MODE_ANSI:    o_color = {20'b0, ansi_idx};
            MODE_UNKNOWN: o_color = {20'b0, ansi_idx};
            default:      o_color = {20'b0, ansi_idx};
        endcase
    end

endmodule
`default_nettype wire

### hw/rtl/terminal_color_downgrade_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// terminal_color_downgrade_core
// Downgrades a text style's colors to the terminal's color mode and masks
// its attributes.
// ----------------------------------------------------------------------------
// path: an accepted item goes to the input reg, then to the result reg
// throughput: one item per cycle when not stalled; single pass between regs
// reset: pipeline empty, color mode rgb, all attributes supported
// ----------------------------------------------------------------------------
module terminal_color_downgrade_core
    import tcd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire t_in_item             i_in_item,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output t_out_item                 o_out_item,
    input  wire logic                 i_cfg_we,
    input  wire logic                 i_cfg_index,
    input  wire logic [CFG_WIDTH-1:0] i_cfg_data
);

    logic [1:0]  r_pal_mode;
    logic [4:0]  r_supp_attrs;
    logic        r_in_valid;
    t_in_item    r_in_item;
    logic        r_out_valid;
    t_out_item   r_out_item;
    t_out_item   n_out_item;
    logic        out_adv;
    logic [23:0] fg_conv;
    logic [23:0] bg_conv;

    assign out_adv    = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || out_adv;

    tcd_conv u_conv_fg (
        .i_rgb   (r_in_item.fg_color),
        .i_mode  (r_pal_mode),
        .o_color (fg_conv)
    );

    tcd_conv u_conv_bg (
        .i_rgb   (r_in_item.bg_color),
        .i_mode  (r_pal_mode),
        .o_color (bg_conv)
    );

    assign n_out_item = {fg_conv, bg_conv, r_in_item.attr_bits & r_supp_attrs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pal_mode   <= PAL_MODE_RESET;
            r_supp_attrs <= SUPP_ATTRS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PAL_MODE:   r_pal_mode   <= i_cfg_data[1:0];
                REG_SUPP_ATTRS: r_supp_attrs <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (out_adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
        if (out_adv && r_in_valid) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
`default_nettype wire
